FILE: sv/bdh_pkg.sv
// shared types and constants of the button debounce and hold detector
// no dependencies
`default_nettype none

package bdh_pkg;

  localparam int CfgWidth = 16;
  localparam int FieldButtons = 4;

  // item operation codes
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_CLEAR_ONE = 2'd1;
  localparam logic [1:0] OP_CLEAR_ALL = 2'd2;

  // per-button event codes
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_PRESSED  = 2'd1;
  localparam logic [1:0] EV_RELEASED = 2'd2;
  localparam logic [1:0] EV_HELD     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [1:0] REG_HOLD         = 2'd1;
  localparam logic [1:0] REG_RECENT_PRESS = 2'd2;

  localparam logic [CfgWidth-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CfgWidth-1:0] HOLD_RESET     = 16'd1000;
  localparam logic [CfgWidth-1:0] RECENT_RESET   = 16'd50;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ticks;
    logic [CfgWidth-1:0] hold_ticks;
    logic [CfgWidth-1:0] recent_press_ticks;
  } cfg_t;

  // state of one button after the current transaction
  typedef struct packed {
    logic       pressed;
    logic       held;
    logic [1:0] evt;
  } lane_stat_t;

endpackage

`default_nettype wire

FILE: sv/bdh_if.sv
// valid/ready channel interfaces for input and result transactions
// no dependencies
`default_nettype none

interface bdh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [3:0] raw_levels;
  logic [1:0] button_index;

  modport source (output valid, op, raw_levels, button_index, input ready);
  modport sink (input valid, op, raw_levels, button_index, output ready);
endinterface

interface bdh_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pressed_flags;
  logic [3:0] held_flags;
  logic [1:0] event_up;
  logic [1:0] event_down;
  logic [1:0] event_select;
  logic [1:0] event_back;
  logic       any_pressed;

  modport source (output valid, pressed_flags, held_flags, event_up, event_down,
                  event_select, event_back, any_pressed, input ready);
  modport sink (input valid, pressed_flags, held_flags, event_up, event_down,
                event_select, event_back, any_pressed, output ready);
endinterface

`default_nettype wire

FILE: sv/bdh_lane.sv
// debounce and hold tracking for one button
// depends on bdh_pkg
`default_nettype none

module bdh_lane import bdh_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       tick_i,
  input  wire logic       clear_i,
  input  wire logic       level_i,
  input  wire cfg_t       cfg_i,
  output lane_stat_t      stat_o
);

  localparam int CmpW = (COUNT_BITS > CfgWidth) ? COUNT_BITS : CfgWidth;

  logic                  last_q, last_d;
  logic [COUNT_BITS-1:0] stable_q, stable_d;
  logic                  pressed_q, pressed_d;
  logic [COUNT_BITS-1:0] age_q, age_d;
  logic                  held_q, held_d;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  always_comb begin
    last_d    = last_q;
    stable_d  = stable_q;
    pressed_d = pressed_q;
    age_d     = age_q;
    held_d    = held_q;
    if (tick_i) begin
      age_d = sat_inc(age_q);
      if (level_i != last_q) begin
        last_d   = level_i;
        stable_d = '0;
      end else begin
        stable_d = sat_inc(stable_q);
      end
      if (CmpW'(stable_d) > CmpW'(cfg_i.debounce_ticks)) begin
        if (!level_i && !pressed_q) begin
          pressed_d = 1'b1;
          age_d     = '0;
          held_d    = 1'b0;
        end else if (level_i && pressed_q) begin
          pressed_d = 1'b0;
          held_d    = 1'b0;
        end else if (!level_i && pressed_q && !held_q &&
                     (CmpW'(age_d) > CmpW'(cfg_i.hold_ticks))) begin
          held_d = 1'b1;
        end
      end
    end
    if (clear_i) begin
      pressed_d = 1'b0;
      held_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 1'b1;
      stable_q  <= '0;
      pressed_q <= 1'b0;
      age_q     <= '0;
      held_q    <= 1'b0;
    end else begin
      last_q    <= last_d;
      stable_q  <= stable_d;
      pressed_q <= pressed_d;
      age_q     <= age_d;
      held_q    <= held_d;
    end
  end

  // event reflects the state after this transaction
  always_comb begin
    stat_o.pressed = pressed_d;
    stat_o.held    = held_d;
    if (pressed_d && (CmpW'(age_d) < CmpW'(cfg_i.recent_press_ticks))) begin
      stat_o.evt = EV_PRESSED;
    end else if (!pressed_d && last_d) begin
      stat_o.evt = EV_RELEASED;
    end else if (held_d) begin
      stat_o.evt = EV_HELD;
    end else begin
      stat_o.evt = EV_NONE;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bdh_merge.sv
// merges the lane states into one result and holds it in the output register
// depends on bdh_pkg and bdh_if
`default_nettype none

module bdh_merge import bdh_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire lane_stat_t stat_i [NUM_BUTTONS],
  output logic            ready_o,
  bdh_out_if.source       out_ch
);

  logic                    valid_q;
  logic [FieldButtons-1:0] pf_d, hf_d, pf_q, hf_q;
  logic [1:0]              ev_d [FieldButtons];
  logic [1:0]              ev_q [FieldButtons];
  logic                    any_d, any_q;

  for (genvar g = 0; g < FieldButtons; g++) begin : g_field
    if (g < NUM_BUTTONS) begin : g_real
      assign pf_d[g] = stat_i[g].pressed;
      assign hf_d[g] = stat_i[g].held;
      assign ev_d[g] = stat_i[g].evt;
    end else begin : g_absent
      assign pf_d[g] = 1'b0;
      assign hf_d[g] = 1'b0;
      assign ev_d[g] = EV_NONE;
    end
  end

  // any_pressed covers every lane, also those beyond the flag fields
  always_comb begin
    any_d = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      any_d = any_d | stat_i[i].pressed;
    end
  end

  assign ready_o = !valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      pf_q  <= pf_d;
      hf_q  <= hf_d;
      ev_q  <= ev_d;
      any_q <= any_d;
    end
  end

  assign out_ch.valid         = valid_q;
  assign out_ch.pressed_flags = pf_q;
  assign out_ch.held_flags    = hf_q;
  assign out_ch.event_up      = ev_q[0];
  assign out_ch.event_down    = ev_q[1];
  assign out_ch.event_select  = ev_q[2];
  assign out_ch.event_back    = ev_q[3];
  assign out_ch.any_pressed   = any_q;

endmodule

`default_nettype wire

FILE: sv/button_debounce_hold_detector_unit.sv
// Debounces NUM_BUTTONS active-low buttons and flags presses, releases and
// long presses. One transaction is taken per clock cycle unless the output
// stalls: every button has its own lane with two saturating counters and
// their compares, and the lanes work side by side. A result appears in the
// output register in the cycle after its transaction is accepted, and a new
// one is accepted while it waits if the output drains. Configuration writes
// are taken in any cycle and must only be issued while the unit is idle.
// depends on bdh_pkg, bdh_if, bdh_lane and bdh_merge
`default_nettype none

module button_debounce_hold_detector_unit import bdh_pkg::*; #(
  parameter int NUM_BUTTONS = 4,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [CfgWidth-1:0] cfg_wdata_i,
  bdh_in_if.sink                   in_ch,
  bdh_out_if.source                out_ch
);

  cfg_t       cfg_q;
  logic       ready;
  logic       accept;
  logic       tick;
  lane_stat_t stat [NUM_BUTTONS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= DEBOUNCE_RESET;
      cfg_q.hold_ticks         <= HOLD_RESET;
      cfg_q.recent_press_ticks <= RECENT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE:     cfg_q.debounce_ticks     <= cfg_wdata_i;
        REG_HOLD:         cfg_q.hold_ticks         <= cfg_wdata_i;
        REG_RECENT_PRESS: cfg_q.recent_press_ticks <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  assign in_ch.ready = ready;
  assign accept      = in_ch.valid && ready;
  assign tick        = accept && (in_ch.op == OP_TICK);

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    logic level;
    logic clear;

    // buttons beyond the raw field read released
    if (g < FieldButtons) begin : g_pin
      assign level = in_ch.raw_levels[g];
    end else begin : g_nopin
      assign level = 1'b1;
    end

    assign clear = accept &&
                   ((in_ch.op == OP_CLEAR_ALL) ||
                    ((in_ch.op == OP_CLEAR_ONE) && (32'(in_ch.button_index) == g)));

    bdh_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tick_i  (tick),
      .clear_i (clear),
      .level_i (level),
      .cfg_i   (cfg_q),
      .stat_o  (stat[g])
    );
  end

  bdh_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .stat_i  (stat),
    .ready_o (ready),
    .out_ch  (out_ch)
  );

  // held only ever set on a pressed button
  a_held_implies_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> ((out_ch.held_flags & ~out_ch.pressed_flags) == '0))
    else $error("held flag without pressed flag");

  a_any_covers_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && (out_ch.pressed_flags != '0)) |-> out_ch.any_pressed)
    else $error("any_pressed low while a pressed flag is set");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_ch.op == OP_CLEAR_ALL)) |=>
      (out_ch.valid && !out_ch.any_pressed && (out_ch.held_flags == '0)))
    else $error("clear all left a flag set");

  a_event_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && (out_ch.event_up == EV_PRESSED)) |-> out_ch.pressed_flags[0])
    else $error("pressed event without pressed flag");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_ch.valid)
    else $error("accepted transaction produced no result");

endmodule

`default_nettype wire
